### rtl/psfp_pkg.sv
// shared constants and types of the particle sensor frame parser
`default_nettype none

package psfp_pkg;

	// frame layout
	localparam int FRAME_BYTES = 22;
	localparam int CNT_W       = 5;

	localparam logic [CNT_W-1:0] SUM_END_IDX   = CNT_W'(FRAME_BYTES - 2);
	localparam logic [CNT_W-1:0] LAST_IDX      = CNT_W'(FRAME_BYTES - 1);
	localparam logic [CNT_W-1:0] PM1_HI_IDX    = CNT_W'(2);
	localparam logic [CNT_W-1:0] PM1_LO_IDX    = CNT_W'(3);
	localparam logic [CNT_W-1:0] PM25_HI_IDX   = CNT_W'(4);
	localparam logic [CNT_W-1:0] PM25_LO_IDX   = CNT_W'(5);
	localparam logic [CNT_W-1:0] PM10_HI_IDX   = CNT_W'(6);
	localparam logic [CNT_W-1:0] PM10_LO_IDX   = CNT_W'(7);

	// header bytes and checksum seed (sum of both header bytes)
	localparam logic [7:0]  HDR_FIRST  = 8'h42;
	localparam logic [7:0]  HDR_SECOND = 8'h4D;
	localparam logic [15:0] SUM_SEED   = 16'h008F;

	// parser phase codes
	localparam logic [1:0] PH_HUNT   = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_BODY   = 2'd2;

	// one decoded reading, handed from the parser to the output stage
	typedef struct packed {
		logic        valid;
		logic [15:0] pm1;
		logic [15:0] pm25;
		logic [15:0] pm10;
	} res_t;

endpackage

`default_nettype wire

### rtl/psfp_parser.sv
// input register, frame state machine and checksum of the frame parser
`default_nettype none

module psfp_parser (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    in_byte,
	input  wire logic          res_ready,
	output psfp_pkg::res_t     res
);

	logic                        valid_s1;
	logic [7:0]                  byte_s1;
	logic                        advance;

	logic [1:0]                  phase_q;
	logic [psfp_pkg::CNT_W-1:0]  count_q;
	logic [15:0]                 sum_q;
	logic [15:0]                 pm1_q;
	logic [15:0]                 pm25_q;
	logic [15:0]                 pm10_q;
	logic [7:0]                  sum_high_q;

	logic                        in_body;
	logic                        at_last;
	logic                        match;
	logic                        emit;

	// input stage moves on unless a finished reading finds the output side full
	assign emit     = valid_s1 && in_body && at_last && match;
	assign advance  = valid_s1 && (!emit || res_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	// end of frame check
	assign in_body = (phase_q == psfp_pkg::PH_BODY);
	assign at_last = (count_q >= psfp_pkg::LAST_IDX);
	assign match   = ({sum_high_q, byte_s1} == sum_q);

	// header hunt, body count and checksum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= psfp_pkg::PH_HUNT;
			count_q <= '0;
			sum_q   <= psfp_pkg::SUM_SEED;
		end else if (advance) begin
			case (phase_q)
				psfp_pkg::PH_HUNT: begin
					if (byte_s1 == psfp_pkg::HDR_FIRST) begin
						phase_q <= psfp_pkg::PH_SECOND;
					end
				end
				psfp_pkg::PH_SECOND: begin
					phase_q <= (byte_s1 == psfp_pkg::HDR_SECOND) ?
						psfp_pkg::PH_BODY : psfp_pkg::PH_HUNT;
				end
				psfp_pkg::PH_BODY: begin
					if (at_last) begin
						phase_q <= psfp_pkg::PH_HUNT;
						count_q <= '0;
						sum_q   <= psfp_pkg::SUM_SEED;
					end else begin
						count_q <= count_q + 1'b1;
						if (count_q < psfp_pkg::SUM_END_IDX) begin
							sum_q <= sum_q + {8'd0, byte_s1};
						end
					end
				end
				default: begin
					phase_q <= psfp_pkg::PH_HUNT;
				end
			endcase
		end
	end

	// capture of the concentration words and the check high byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm1_q      <= '0;
			pm25_q     <= '0;
			pm10_q     <= '0;
			sum_high_q <= '0;
		end else if (advance && in_body) begin
			if (count_q == psfp_pkg::PM1_HI_IDX || count_q == psfp_pkg::PM1_LO_IDX) begin
				pm1_q <= {pm1_q[7:0], byte_s1};
			end
			if (count_q == psfp_pkg::PM25_HI_IDX || count_q == psfp_pkg::PM25_LO_IDX) begin
				pm25_q <= {pm25_q[7:0], byte_s1};
			end
			if (count_q == psfp_pkg::PM10_HI_IDX || count_q == psfp_pkg::PM10_LO_IDX) begin
				pm10_q <= {pm10_q[7:0], byte_s1};
			end
			if (count_q == psfp_pkg::SUM_END_IDX) begin
				sum_high_q <= byte_s1;
			end
		end
	end

	// result toward the output stage
	always_comb begin
		res.valid = emit;
		res.pm1   = pm1_q;
		res.pm25  = pm25_q;
		res.pm10  = pm10_q;
	end

	// a result only comes from the last body byte
	a_res_at_last: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (phase_q == psfp_pkg::PH_BODY && count_q == psfp_pkg::LAST_IDX))
		else $error("result outside the last body byte");

	// frame end restarts count and sum
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && in_body && at_last) |=>
			(count_q == '0 && sum_q == psfp_pkg::SUM_SEED && phase_q == psfp_pkg::PH_HUNT))
		else $error("frame end did not restart the parser");

	// count stays at zero outside the body
	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != psfp_pkg::PH_BODY) |-> (count_q == '0))
		else $error("body count moved outside the body");

endmodule

`default_nettype wire

### rtl/psfp_out_stage.sv
// output register of the frame parser, holds one reading until taken
`default_nettype none

module psfp_out_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire psfp_pkg::res_t res,
	output logic                res_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [47:0]         out_data
);

	logic        valid_q;
	logic [47:0] data_q;

	// room when empty or when the held reading leaves this cycle
	assign res_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res.valid;
		end
	end

	// pack fields from the lowest bit up
	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			data_q <= {res.pm10, res.pm25, res.pm1};
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

`default_nettype wire

### rtl/particle_sensor_frame_parser.sv
// top level of the particle sensor frame parser
`default_nettype none

// Takes one sensor link byte per transaction, hunts for the 0x42 0x4D header,
// collects the body and checks the 16-bit sum of the header and the bytes ahead
// of the check word against that big-endian check word in the last two body
// bytes. A good frame yields one transaction carrying the PM1.0, PM2.5 and
// PM10 words; a bad frame yields nothing. A byte is accepted every cycle
// unless a good frame ends while a reading is still held; the last byte passes
// the input register and the end of frame check, and the reading is then held
// in an output register. Input keeps flowing while a reading waits there; only
// the last byte of the next good frame stalls until the held reading is taken.

module particle_sensor_frame_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata    // [15:0] pm1_value, [31:16] pm25_value, [47:32] pm10_value
);

	psfp_pkg::res_t res;
	logic           res_ready;

	psfp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.res_ready (res_ready),
		.res       (res)
	);

	psfp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.res_ready (res_ready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

`default_nettype wire
